// ----- sv/ppm_p6_stream_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// PPM P6 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PPM_P6_STREAM_DECODER_ASSERT_SVH
`define PPM_P6_STREAM_DECODER_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define PPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the next edge after the antecedent.
`define PPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ppd_pkg.sv -----
// ----------------------------------------------------------------------------
// PPM P6 stream decoder package
// Shared types, result codes and character constants.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned DimBitsDefault = 16;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC  = 3'd0,
    ERR_NUMBER = 3'd1,
    ERR_DIM    = 3'd2,
    ERR_MAXVAL = 3'd3,
    ERR_TRUNC  = 3'd4
  } err_e;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] MAXVAL   = 8'hFF;
  localparam logic [7:0] ALPHA    = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  error_code;
    logic        final_pixel;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ----- sv/ppd_in_if.sv -----
// ----------------------------------------------------------------------------
// PPM P6 byte channel
// Valid/ready channel carrying one file byte and the end-of-file flag.
// ----------------------------------------------------------------------------
interface ppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_file;

  modport source (output valid, output byte_req, output end_of_file, input ready);
  modport sink   (input valid, input byte_req, input end_of_file, output ready);
endinterface

// ----- sv/ppd_out_if.sv -----
// ----------------------------------------------------------------------------
// PPM P6 result channel
// Valid/ready channel carrying one header, pixel or error item.
// ----------------------------------------------------------------------------
interface ppd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  error_code;
  logic        final_pixel;

  modport source (output valid, output kind, output red, output green, output blue,
                  output alpha, output image_width, output image_height,
                  output error_code, output final_pixel, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input alpha, input image_width, input image_height,
                  input error_code, input final_pixel, output ready);
endinterface

// ----- sv/ppd_parser.sv -----
// ----------------------------------------------------------------------------
// PPM P6 parser
// Header tokeniser and pixel assembler; one byte per accepted item.
// ----------------------------------------------------------------------------
`include "ppm_p6_stream_decoder_assert.svh"

module ppd_parser #(
  parameter int unsigned DIM_BITS = ppd_pkg::DimBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic             eof_i,
  output logic             res_valid_o,
  output ppd_pkg::result_t res_o
);

  localparam int unsigned AW = DIM_BITS + 1;
  localparam int unsigned MW = DIM_BITS + 5;
  localparam logic [AW-1:0] AccSat = {1'b1, {DIM_BITS{1'b0}}};

  logic [2:0]          phase_q, phase_d;
  logic                in_comment_q, in_comment_d;
  logic                tok_q, tok_d;
  logic [1:0]          magic_q, magic_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [1:0]          bip_q, bip_d;
  logic [7:0]          red_q, red_d;
  logic [7:0]          green_q, green_d;

  logic [MW-1:0]       mul10;
  logic [AW-1:0]       col_inc, row_inc;
  logic                last_col, last_row, fin;
  logic                emit;
  ppd_pkg::result_t    res;
  logic                keep;

  assign mul10 = (MW'(acc_q) << 3) + (MW'(acc_q) << 1) + MW'(byte_i[3:0]);
  assign col_inc  = AW'(col_q) + AW'(1);
  assign row_inc  = AW'(row_q) + AW'(1);
  assign last_col = col_inc >= AW'(width_q);
  assign last_row = row_inc >= AW'(height_q);
  assign fin      = last_col && last_row;

  always_comb begin
    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    tok_d        = tok_q;
    magic_d      = magic_q;
    acc_d        = acc_q;
    width_d      = width_q;
    height_d     = height_q;
    col_d        = col_q;
    row_d        = row_q;
    bip_d        = bip_q;
    red_d        = red_q;
    green_d      = green_q;
    emit         = 1'b0;
    res          = '0;
    keep         = 1'b0;

    if (phase_q >= ppd_pkg::PH_DONE) begin
      if (eof_i) begin
        phase_d      = ppd_pkg::PH_MAGIC;
        in_comment_d = 1'b0;
        tok_d        = 1'b0;
        magic_d      = '0;
        acc_d        = '0;
        width_d      = '0;
        height_d     = '0;
        col_d        = '0;
        row_d        = '0;
        bip_d        = '0;
        red_d        = '0;
        green_d      = '0;
      end
    end else begin
      if (in_comment_q) begin
        if (byte_i == ppd_pkg::CH_LF) begin
          in_comment_d = 1'b0;
        end
      end else if (phase_q == ppd_pkg::PH_DATA) begin
        unique case (bip_q)
          2'd0: begin
            red_d = byte_i;
            bip_d = 2'd1;
          end
          2'd1: begin
            green_d = byte_i;
            bip_d   = 2'd2;
          end
          default: begin
            bip_d           = 2'd0;
            emit            = 1'b1;
            res.kind        = ppd_pkg::KIND_PIXEL;
            res.red         = red_q;
            res.green       = green_q;
            res.blue        = byte_i;
            res.alpha       = ppd_pkg::ALPHA;
            res.final_pixel = fin;
            if (fin) begin
              phase_d = ppd_pkg::PH_DONE;
            end else if (last_col) begin
              col_d = '0;
              row_d = row_inc[DIM_BITS-1:0];
            end else begin
              col_d = col_inc[DIM_BITS-1:0];
            end
          end
        endcase
      end else if (ppd_pkg::is_space(byte_i) || (byte_i == ppd_pkg::CH_HASH)) begin
        if (tok_q) begin
          tok_d = 1'b0;
          acc_d = '0;
          unique case (phase_q)
            ppd_pkg::PH_MAGIC: begin
              if (magic_q != 2'd2) begin
                emit           = 1'b1;
                res.kind       = ppd_pkg::KIND_ERROR;
                res.error_code = ppd_pkg::ERR_MAGIC;
                phase_d        = ppd_pkg::PH_ERROR;
              end else begin
                phase_d = ppd_pkg::PH_WIDTH;
              end
            end
            ppd_pkg::PH_WIDTH, ppd_pkg::PH_HEIGHT: begin
              if ((acc_q == '0) || acc_q[DIM_BITS]) begin
                emit           = 1'b1;
                res.kind       = ppd_pkg::KIND_ERROR;
                res.error_code = ppd_pkg::ERR_DIM;
                phase_d        = ppd_pkg::PH_ERROR;
              end else if (phase_q == ppd_pkg::PH_WIDTH) begin
                width_d = acc_q[DIM_BITS-1:0];
                phase_d = ppd_pkg::PH_HEIGHT;
              end else begin
                height_d = acc_q[DIM_BITS-1:0];
                phase_d  = ppd_pkg::PH_MAXVAL;
              end
            end
            default: begin
              emit = 1'b1;
              if (acc_q != AW'(ppd_pkg::MAXVAL)) begin
                res.kind       = ppd_pkg::KIND_ERROR;
                res.error_code = ppd_pkg::ERR_MAXVAL;
                phase_d        = ppd_pkg::PH_ERROR;
              end else begin
                res.kind         = ppd_pkg::KIND_HEADER;
                res.image_width  = 16'(width_q);
                res.image_height = 16'(height_q);
                phase_d          = ppd_pkg::PH_DATA;
              end
            end
          endcase
        end
        if ((byte_i == ppd_pkg::CH_HASH) && (phase_d != ppd_pkg::PH_ERROR)) begin
          in_comment_d = 1'b1;
        end
      end else begin
        tok_d = 1'b1;
        if (phase_q == ppd_pkg::PH_MAGIC) begin
          if ((magic_q == 2'd0) && (byte_i == ppd_pkg::CH_P)) begin
            magic_d = 2'd1;
          end else if ((magic_q == 2'd1) && (byte_i == ppd_pkg::CH_SIX)) begin
            magic_d = 2'd2;
          end else begin
            emit           = 1'b1;
            res.kind       = ppd_pkg::KIND_ERROR;
            res.error_code = ppd_pkg::ERR_MAGIC;
            phase_d        = ppd_pkg::PH_ERROR;
          end
        end else if ((byte_i < ppd_pkg::CH_ZERO) || (byte_i > ppd_pkg::CH_NINE)) begin
          emit           = 1'b1;
          res.kind       = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_NUMBER;
          phase_d        = ppd_pkg::PH_ERROR;
        end else if (mul10 > MW'(AccSat)) begin
          acc_d = AccSat;
        end else begin
          acc_d = mul10[AW-1:0];
        end
      end

      if (eof_i) begin
        keep = emit && ((res.kind == ppd_pkg::KIND_ERROR) ||
                        ((res.kind == ppd_pkg::KIND_PIXEL) && res.final_pixel));
        if (!keep) begin
          res            = '0;
          res.kind       = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_TRUNC;
        end
        emit         = 1'b1;
        phase_d      = ppd_pkg::PH_MAGIC;
        in_comment_d = 1'b0;
        tok_d        = 1'b0;
        magic_d      = '0;
        acc_d        = '0;
        width_d      = '0;
        height_d     = '0;
        col_d        = '0;
        row_d        = '0;
        bip_d        = '0;
        red_d        = '0;
        green_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ppd_pkg::PH_MAGIC;
      in_comment_q <= 1'b0;
      tok_q        <= 1'b0;
      magic_q      <= '0;
      acc_q        <= '0;
      width_q      <= '0;
      height_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      bip_q        <= '0;
      red_q        <= '0;
      green_q      <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      in_comment_q <= in_comment_d;
      tok_q        <= tok_d;
      magic_q      <= magic_d;
      acc_q        <= acc_d;
      width_q      <= width_d;
      height_q     <= height_d;
      col_q        <= col_d;
      row_q        <= row_d;
      bip_q        <= bip_d;
      red_q        <= red_d;
      green_q      <= green_d;
    end
  end

  assign res_valid_o = accept_i && emit;
  assign res_o       = res;

  `PPD_ASSERT_NEXT(a_eof_resets, accept_i && eof_i, phase_q == ppd_pkg::PH_MAGIC, "eof did not reset parser")
  `PPD_ASSERT_SAME(a_pixel_alpha, res_valid_o && (res_o.kind == ppd_pkg::KIND_PIXEL), res_o.alpha == ppd_pkg::ALPHA, "pixel alpha wrong")
  `PPD_ASSERT_SAME(a_eof_emits, accept_i && eof_i && (phase_q < ppd_pkg::PH_DONE), res_valid_o, "eof gave no result")

endmodule

// ----- sv/ppd_out_buf.sv -----
// ----------------------------------------------------------------------------
// PPM P6 result buffer
// Two-entry output register with skid slot; decouples parser from sink.
// ----------------------------------------------------------------------------
`include "ppm_p6_stream_decoder_assert.svh"

module ppd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppd_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output ppd_pkg::result_t data_o
);

  logic [1:0]       count_q, count_d;
  ppd_pkg::result_t slot0_q, slot0_d;
  ppd_pkg::result_t slot1_q, slot1_d;
  logic             pop;

  assign valid_o = count_q != 2'd0;
  assign ready_o = count_q != 2'd2;
  assign data_o  = slot0_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    count_d = count_q;
    priority if (push_i && pop) begin
      if (count_q == 2'd1) begin
        slot0_d = data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = data_i;
      end
    end else if (pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        slot0_d = data_i;
      end else begin
        slot1_d = data_i;
      end
      count_d = count_q + 2'd1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  `PPD_ASSERT_SAME(a_no_overflow, push_i, count_q != 2'd2, "push into full buffer")
  `PPD_ASSERT_NEXT(a_push_visible, push_i, valid_o, "pushed item not visible")
  `PPD_ASSERT_SAME(a_count_range, 1'b1, count_q != 2'd3, "buffer count out of range")

endmodule

// ----- sv/ppm_p6_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// PPM P6 stream decoder
// Parses a binary PPM file byte by byte into header, pixel and error items.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one file byte per item, end_of_file high on the last one.
//   out_o carries one result item per header, pixel or error; most bytes
//   give none. The header item comes when maxval 255 is parsed, then one
//   RGBA pixel every third data byte, the last flagged by final_pixel.
//   The last byte always yields an item unless the image already ended or
//   an error was reported; a short file ends with a truncated error.
// Timing:
//   one byte a cycle while the result buffer has room; each result is
//   registered in the result buffer before it appears on out_o.
// Reset:
//   rst_ni clears the parser to expect the magic token and empties the
//   result buffer.
// Stall:
//   a two-entry result buffer keeps in_i open while one item waits; in_i
//   ready drops only when both entries are held.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder #(
  parameter int unsigned DIM_BITS = ppd_pkg::DimBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppd_in_if.sink    in_i,
  ppd_out_if.source out_o
);

  logic             accept;
  logic             res_valid;
  ppd_pkg::result_t res;
  ppd_pkg::result_t head;
  logic             buf_ready;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  ppd_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .byte_i     (in_i.byte_req),
    .eof_i      (in_i.end_of_file),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ppd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .data_i     (res),
    .ready_o    (buf_ready),
    .valid_o    (out_o.valid),
    .pop_ready_i(out_o.ready),
    .data_o     (head)
  );

  assign out_o.kind         = head.kind;
  assign out_o.red          = head.red;
  assign out_o.green        = head.green;
  assign out_o.blue         = head.blue;
  assign out_o.alpha        = head.alpha;
  assign out_o.image_width  = head.image_width;
  assign out_o.image_height = head.image_height;
  assign out_o.error_code   = head.error_code;
  assign out_o.final_pixel  = head.final_pixel;

endmodule

// ----- sim/ppm_p6_stream_decoder_test.sv -----
// ----------------------------------------------------------------------------
// PPM P6 stream decoder testbench
// Feeds whole and broken P6 files byte by byte under random idling on both
// channels, predicts every header, pixel and error item in step with the
// accepted bytes and checks each item on the result channel field by field.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_test;

  localparam longint unsigned DimMax = (64'd1 << ppd_pkg::DimBitsDefault) - 1;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } stream_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       tx_valid = 1'b0;
  logic [7:0] tx_byte = '0;
  logic       tx_last = 1'b0;
  logic       rx_ready = 1'b0;

  ppd_in_if  in_if ();
  ppd_out_if out_if ();

  assign in_if.valid       = tx_valid;
  assign in_if.byte_req    = tx_byte;
  assign in_if.end_of_file = tx_last;
  assign out_if.ready      = rx_ready;

  ppm_p6_stream_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  stream_byte_t     pending_bytes[$];
  ppd_pkg::result_t expected_results[$];
  logic [7:0]       file_text[$];

  int unsigned fail_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned files_built = 0;
  int unsigned results_checked = 0;
  int unsigned headers_seen = 0;
  int unsigned pixels_seen = 0;
  int unsigned final_pixels_seen = 0;
  int unsigned errors_by_code[5] = '{default: 0};
  int unsigned cycle_count = 0;

  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_calm = 0;
  int unsigned long_hold = 0;
  int unsigned holds_done = 0;

  // parser state of the predictor
  logic [2:0]      p_phase;
  bit              p_comment;
  bit              p_token;
  logic [1:0]      p_magic;
  longint unsigned p_acc;
  int unsigned     p_width;
  int unsigned     p_height;
  int unsigned     p_col;
  int unsigned     p_row;
  logic [1:0]      p_pos;
  logic [7:0]      p_red;
  logic [7:0]      p_green;

  function automatic void parser_reset();
    p_phase   = ppd_pkg::PH_MAGIC;
    p_comment = 1'b0;
    p_token   = 1'b0;
    p_magic   = '0;
    p_acc     = 0;
    p_width   = 0;
    p_height  = 0;
    p_col     = 0;
    p_row     = 0;
    p_pos     = '0;
    p_red     = '0;
    p_green   = '0;
  endfunction

  function automatic void flag_error(input ppd_pkg::err_e code, output ppd_pkg::result_t res);
    res            = '0;
    res.kind       = ppd_pkg::KIND_ERROR;
    res.error_code = code;
    p_phase        = ppd_pkg::PH_ERROR;
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic last,
                                      output bit produced, output ppd_pkg::result_t res);
    longint unsigned v;
    bit              fin;
    produced = 1'b0;
    res      = '0;
    if (p_phase == ppd_pkg::PH_DONE || p_phase >= ppd_pkg::PH_ERROR) begin
      if (last) parser_reset();
    end else begin
      if (p_comment) begin
        if (c == ppd_pkg::CH_LF) p_comment = 1'b0;
      end else if (p_phase == ppd_pkg::PH_DATA) begin
        if (p_pos == 0) begin
          p_red = c;
          p_pos = 1;
        end else if (p_pos == 1) begin
          p_green = c;
          p_pos   = 2;
        end else begin
          p_pos = 0;
          fin = (p_row + 1 >= p_height) && (p_col + 1 >= p_width);
          res.kind        = ppd_pkg::KIND_PIXEL;
          res.red         = p_red;
          res.green       = p_green;
          res.blue        = c;
          res.alpha       = ppd_pkg::ALPHA;
          res.final_pixel = fin;
          produced = 1'b1;
          if (fin) begin
            p_phase = ppd_pkg::PH_DONE;
          end else if (p_col + 1 >= p_width) begin
            p_col = 0;
            p_row++;
          end else begin
            p_col++;
          end
        end
      end else if (c == ppd_pkg::CH_SPACE || (c >= ppd_pkg::CH_TAB && c <= ppd_pkg::CH_CR) ||
                   c == ppd_pkg::CH_HASH) begin
        if (p_token) begin
          v       = p_acc;
          p_token = 1'b0;
          p_acc   = 0;
          case (p_phase)
            ppd_pkg::PH_MAGIC: begin
              if (p_magic != 2) begin
                flag_error(ppd_pkg::ERR_MAGIC, res);
                produced = 1'b1;
              end else begin
                p_phase = ppd_pkg::PH_WIDTH;
              end
            end
            ppd_pkg::PH_WIDTH, ppd_pkg::PH_HEIGHT: begin
              if (v == 0 || v > DimMax) begin
                flag_error(ppd_pkg::ERR_DIM, res);
                produced = 1'b1;
              end else if (p_phase == ppd_pkg::PH_WIDTH) begin
                p_width = int'(v);
                p_phase = ppd_pkg::PH_HEIGHT;
              end else begin
                p_height = int'(v);
                p_phase  = ppd_pkg::PH_MAXVAL;
              end
            end
            default: begin
              if (v != 255) begin
                flag_error(ppd_pkg::ERR_MAXVAL, res);
              end else begin
                p_phase          = ppd_pkg::PH_DATA;
                res.kind         = ppd_pkg::KIND_HEADER;
                res.image_width  = 16'(p_width);
                res.image_height = 16'(p_height);
              end
              produced = 1'b1;
            end
          endcase
        end
        if (c == ppd_pkg::CH_HASH && p_phase != ppd_pkg::PH_ERROR) p_comment = 1'b1;
      end else begin
        p_token = 1'b1;
        if (p_phase == ppd_pkg::PH_MAGIC) begin
          if (p_magic == 0 && c == ppd_pkg::CH_P) begin
            p_magic = 1;
          end else if (p_magic == 1 && c == ppd_pkg::CH_SIX) begin
            p_magic = 2;
          end else begin
            flag_error(ppd_pkg::ERR_MAGIC, res);
            produced = 1'b1;
          end
        end else if (c < ppd_pkg::CH_ZERO || c > ppd_pkg::CH_NINE) begin
          flag_error(ppd_pkg::ERR_NUMBER, res);
          produced = 1'b1;
        end else begin
          v = p_acc * 10 + longint'(c - ppd_pkg::CH_ZERO);
          if (v > DimMax + 1) v = DimMax + 1;
          p_acc = v;
        end
      end
      if (last) begin
        if (!(produced && (res.kind == ppd_pkg::KIND_ERROR ||
                           (res.kind == ppd_pkg::KIND_PIXEL && res.final_pixel)))) begin
          res            = '0;
          res.kind       = ppd_pkg::KIND_ERROR;
          res.error_code = ppd_pkg::ERR_TRUNC;
        end
        produced = 1'b1;
        parser_reset();
      end
    end
  endfunction

  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---- file building ----

  function automatic void append_byte(input logic [7:0] b);
    file_text.insert(file_text.size(), b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void add_random(input int unsigned n);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endfunction

  // whitespace between tokens, now and then a comment; a single separator
  // after maxval so that the data starts where it should
  function automatic void add_gap(input bit single);
    logic [7:0]  b;
    int unsigned r;
    if ($urandom_range(0, 5) == 0) begin
      append_byte(ppd_pkg::CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        append_byte(b == ppd_pkg::CH_LF ? ppd_pkg::CH_P : b);
      end
      append_byte(ppd_pkg::CH_LF);
    end
    if (!single || file_text[$] != ppd_pkg::CH_LF) begin
      repeat (single ? 1 : $urandom_range(1, 3)) begin
        r = $urandom_range(0, 5);
        append_byte(r == 5 ? ppd_pkg::CH_SPACE : 8'(ppd_pkg::CH_TAB + r));
      end
    end
  endfunction

  function automatic void add_number(input int unsigned v);
    if ($urandom_range(0, 7) == 0) add_text("0");
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_bad_number();
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) append_byte(8'(ppd_pkg::CH_ZERO + $urandom_range(0, 9)));
    do b = 8'($urandom_range(0, 255));
    while ((b >= ppd_pkg::CH_ZERO && b <= ppd_pkg::CH_NINE) || b == ppd_pkg::CH_HASH ||
           b == ppd_pkg::CH_SPACE || (b >= ppd_pkg::CH_TAB && b <= ppd_pkg::CH_CR));
    append_byte(b);
    repeat ($urandom_range(0, 2)) append_byte(8'(ppd_pkg::CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void commit_file(input int unsigned keep, input bit drain);
    stream_byte_t item;
    for (int unsigned i = 0; i < keep; i++) begin
      item.data  = file_text[i];
      item.last  = (i == keep - 1);
      item.drain = drain && (i == 0);
      pending_bytes.insert(pending_bytes.size(), item);
    end
    file_text.delete();
    files_built++;
  endfunction

  function automatic void make_file();
    int unsigned mode, fault, pick, w, h, data_len, keep;
    int unsigned dims[2];
    mode  = $urandom_range(0, 99);
    fault = (mode >= 60 && mode < 84) ? $urandom_range(0, 5) : 6;
    pick  = $urandom_range(0, 1);
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    file_text.delete();
    if (mode >= 92) begin
      add_random($urandom_range(1, 12));
    end else begin
      if ($urandom_range(0, 4) == 0) add_gap(1'b0);
      if (fault == 0) begin
        case ($urandom_range(0, 4))
          0: add_text("P");
          1: add_text("P5");
          2: add_text("P66");
          3: begin
            add_random(1);
            add_text("6");
          end
          default: add_text("p6");
        endcase
      end else begin
        add_text("P6");
      end
      add_gap(1'b0);
      dims[0] = w;
      dims[1] = h;
      for (int t = 0; t < 2; t++) begin
        if (fault == 1 && t == pick) begin
          add_bad_number();
        end else if (fault == 2 && t == pick) begin
          if ($urandom_range(0, 1) != 0) add_text("0");
          else add_text("000");
        end else if (fault == 3 && t == pick) begin
          case ($urandom_range(0, 2))
            0: add_text("65536");
            1: add_number($urandom_range(65536, 99999999));
            default: begin
              dims[t] = 65535;
              add_text("65535");
            end
          endcase
        end else begin
          add_number(dims[t]);
        end
        add_gap(1'b0);
      end
      w = dims[0];
      h = dims[1];
      if (fault == 4) begin
        case ($urandom_range(0, 5))
          0: add_text("254");
          1: add_text("256");
          2: add_text("0");
          3: add_text("65535");
          4: add_text("2550");
          default: add_text("99999999");
        endcase
      end else if (fault == 5) begin
        add_bad_number();
      end else begin
        add_number(255);
      end
      add_gap(1'b1);
      data_len = 3 * w * h;
      if (data_len > 300) data_len = $urandom_range(0, 30);
      add_random(data_len);
      if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 4));
    end
    keep = file_text.size();
    if (mode >= 84 && mode < 92 && keep > 1) keep = $urandom_range(1, keep - 1);
    commit_file(keep, files_built % 8 == 4);
  endfunction

  // ---- byte driver ----

  always @(posedge clk_i) begin : byte_driver
    stream_byte_t     next_item;
    bit               produced;
    ppd_pkg::result_t res;
    if (rst_ni) begin
      if (tx_valid && in_if.ready) begin
        decode_byte(tx_byte, tx_last, produced, res);
        if (produced) expected_results.insert(expected_results.size(), res);
        bytes_accepted++;
      end
      if (!tx_valid || in_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          tx_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain && expected_results.size() != 0)) begin
          next_item = pending_bytes.pop_front();
          tx_valid <= 1'b1;
          tx_byte  <= next_item.data;
          tx_last  <= next_item.last;
          tx_gap = next_gap(tx_calm);
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ----

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: item %0d %s mismatch, expected %0d, actual %0d",
               $time, results_checked, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    ppd_pkg::result_t seen;
    ppd_pkg::result_t want;
    if (rst_ni) begin
      if (out_if.valid && rx_ready) begin
        seen.kind         = out_if.kind;
        seen.red          = out_if.red;
        seen.green        = out_if.green;
        seen.blue         = out_if.blue;
        seen.alpha        = out_if.alpha;
        seen.image_width  = out_if.image_width;
        seen.image_height = out_if.image_height;
        seen.error_code   = out_if.error_code;
        seen.final_pixel  = out_if.final_pixel;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item, expected none, actual kind %0d code %0d",
                   $time, seen.kind, seen.error_code);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, seen.kind);
          check_field("red", want.red, seen.red);
          check_field("green", want.green, seen.green);
          check_field("blue", want.blue, seen.blue);
          check_field("alpha", want.alpha, seen.alpha);
          check_field("image_width", want.image_width, seen.image_width);
          check_field("image_height", want.image_height, seen.image_height);
          check_field("error_code", want.error_code, seen.error_code);
          check_field("final_pixel", want.final_pixel, seen.final_pixel);
          if (want.kind == ppd_pkg::KIND_HEADER) headers_seen++;
          else if (want.kind == ppd_pkg::KIND_PIXEL) begin
            pixels_seen++;
            if (want.final_pixel) final_pixels_seen++;
          end else if (want.error_code <= ppd_pkg::ERR_TRUNC) begin
            errors_by_code[want.error_code]++;
          end
        end
        results_checked++;
      end
    end
  end

  // ---- receiver readiness ----

  always @(posedge clk_i) begin : ready_gen
    if (rst_ni) begin
      // long back-pressure so the result buffer fills and the input stalls
      if (holds_done < 2 && results_checked >= (holds_done == 0 ? 60 : 250)) begin
        long_hold = 300;
        holds_done++;
      end
      if (long_hold != 0) begin
        long_hold--;
        rx_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
        rx_gap = next_gap(rx_calm);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run timed out, %0d items still expected", $time, expected_results.size());
      $display("ppm_p6_stream_decoder_test NOT OK");
      $finish;
    end
  end

  // ---- stimulus and end of run ----

  initial begin
    parser_reset();

    // whole 1x1 image: comment after magic, tab and CR separators, LF after maxval
    add_text("P6#");
    append_byte(8'h80);
    append_byte(ppd_pkg::CH_LF);
    add_text("1");
    append_byte(ppd_pkg::CH_TAB);
    add_text("1");
    append_byte(ppd_pkg::CH_CR);
    add_text("255");
    append_byte(ppd_pkg::CH_LF);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(ppd_pkg::CH_HASH);
    commit_file(file_text.size(), 1'b0);
    // error on the last byte itself
    add_text("X");
    commit_file(1, 1'b0);
    // file cut inside the header
    add_text("P6 1");
    commit_file(4, 1'b0);
    // last byte after an error gives nothing
    add_text("P5 ");
    commit_file(3, 1'b0);

    while (pending_bytes.size() < 1400) make_file();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || tx_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Streamed %0d bytes in %0d files; %0d headers, %0d pixels, %0d images complete.",
             bytes_accepted, files_built, headers_seen, pixels_seen, final_pixels_seen);
    $display("Errors: magic %0d, number %0d, dimension %0d, maxval %0d, truncated %0d.",
             errors_by_code[ppd_pkg::ERR_MAGIC], errors_by_code[ppd_pkg::ERR_NUMBER],
             errors_by_code[ppd_pkg::ERR_DIM], errors_by_code[ppd_pkg::ERR_MAXVAL],
             errors_by_code[ppd_pkg::ERR_TRUNC]);
    if (fail_count == 0) begin
      $display("ppm_p6_stream_decoder_test OK");
    end else begin
      $display("ppm_p6_stream_decoder_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- ppm_p6_stream_decoder.f -----
+incdir+sv
sv/ppd_pkg.sv
sv/ppd_in_if.sv
sv/ppd_out_if.sv
sv/ppd_parser.sv
sv/ppd_out_buf.sv
sv/ppm_p6_stream_decoder.sv
sim/ppm_p6_stream_decoder_test.sv
